/* hw/rtl/slpg_pkg.sv */
// Shared types and constants of the simplex-lattice point generator.
package slpg_pkg;

   localparam int NUM_W      = 8;   // numerator and partition count width
   localparam int D_W        = 4;   // dimension register width
   localparam int ADDR_W     = 3;   // register port byte address width
   localparam int DATA_W     = 32;  // register port data width
   localparam int QUEUE_DEPTH = 2;  // points buffered between front and back
   localparam int DIV_BITS   = 4;   // quotient bits resolved per divider cycle

   localparam logic [NUM_W-1:0] PARTITIONS_RESET = 8'd12;
   localparam logic [D_W-1:0]   DIMENSIONS_RESET = 4'd3;

   typedef enum logic [0:0] {
      REG_PARTITIONS = 1'b0,
      REG_DIMENSIONS = 1'b1
   } reg_index_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_DIVIDE
   } back_state_type;

   // Effective configuration: h never zero, d clamped to the legal range.
   typedef struct packed {
      logic [NUM_W-1:0] h;
      logic [D_W-1:0]   d;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

/* hw/rtl/simplex_lattice_point_generator_unit.sv */
// Top level of the simplex-lattice (Das-Dennis) reference point generator.
//
// Each request transfer produces one point of the lattice as D result transfers,
// coordinate 0 first: the numerator n (0..H) and floor(n * 2^FRACTION_BITS / H)
// as an unsigned 1.FRACTION_BITS fraction. The front end takes a request every
// cycle while its two-entry point queue has room, works out the point and steps
// the walk in that same cycle. The back end owns the rate: a restoring divider
// resolving 4 quotient bits a cycle works through each coordinate in turn and
// returns to idle between points. A result waits in an output register, and
// the divider keeps working on the next coordinate while it waits, holding its
// last quotient bits until the output register is free. A write to either
// register restarts the walk at the first point; write registers only while no
// results are outstanding.
module simplex_lattice_point_generator_unit #(
   parameter int MAX_DIMENSIONS = 8,
   parameter int FRACTION_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // request queue side
   input  logic                                push,
   output logic                                full,
   input  logic                                req_restart,
   // result queue side
   output logic                                empty,
   input  logic                                pop,
   output logic [$clog2(MAX_DIMENSIONS)-1:0]   rsp_coordinate_index,
   output logic [slpg_pkg::NUM_W-1:0]          rsp_numerator,
   output logic [FRACTION_BITS:0]              rsp_fraction,
   output logic                                rsp_last_of_point,
   output logic                                rsp_final_point,
   // register port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [slpg_pkg::ADDR_W-1:0]         paddr,
   input  logic [slpg_pkg::DATA_W-1:0]         pwdata,
   output logic [slpg_pkg::DATA_W-1:0]         prdata,
   output logic                                pready
);

   localparam int NW      = slpg_pkg::NUM_W;
   localparam int DW      = slpg_pkg::D_W;
   localparam int ENTRY_W = MAX_DIMENSIONS * NW + 1;

   logic [NW-1:0]           partitions_ff;
   logic [DW-1:0]           dimensions_ff;
   slpg_pkg::reg_index_type reg_index;
   logic                    reg_write;
   slpg_pkg::cfg_type       cfg;

   slpg_pkg::q_status_type  q_status;
   logic                    q_push, q_pop;
   logic [ENTRY_W-1:0]      q_push_data, q_head_data;

   // Registers sit on 4-byte boundaries; the word address picks the register.
   assign pready    = 1'b1;
   assign reg_index = slpg_pkg::reg_index_type'(paddr[2]);
   assign reg_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         partitions_ff <= slpg_pkg::PARTITIONS_RESET;
         dimensions_ff <= slpg_pkg::DIMENSIONS_RESET;
      end else if (reg_write) begin
         case (reg_index)
            slpg_pkg::REG_PARTITIONS: partitions_ff <= pwdata[NW-1:0];
            slpg_pkg::REG_DIMENSIONS: dimensions_ff <= pwdata[DW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         slpg_pkg::REG_PARTITIONS: prdata = slpg_pkg::DATA_W'(partitions_ff);
         slpg_pkg::REG_DIMENSIONS: prdata = slpg_pkg::DATA_W'(dimensions_ff);
         default:                  prdata = '0;
      endcase
   end

   // Effective settings: zero partitions act as one, dimensions clamp to the
   // range two up to MAX_DIMENSIONS.
   always_comb begin
      cfg.h = (partitions_ff == '0) ? NW'(1) : partitions_ff;
      if (dimensions_ff < DW'(2)) begin
         cfg.d = DW'(2);
      end else if (int'(dimensions_ff) > MAX_DIMENSIONS) begin
         cfg.d = DW'(MAX_DIMENSIONS);
      end else begin
         cfg.d = dimensions_ff;
      end
   end

   assign full = q_status.full;

   // Front: hold the walk state, emit one whole point per request.
   slpg_front #(
      .MAX_DIMENSIONS (MAX_DIMENSIONS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .clear    (reg_write),
      .push     (push),
      .restart  (req_restart),
      .q_status (q_status),
      .q_push   (q_push),
      .q_data   (q_push_data)
   );

   // Point queue: decouple request intake from result delivery.
   slpg_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .head_data (q_head_data),
      .status    (q_status)
   );

   // Back: divide each coordinate and hand results out one per transfer.
   slpg_back #(
      .MAX_DIMENSIONS (MAX_DIMENSIONS),
      .FRACTION_BITS  (FRACTION_BITS)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg),
      .q_status             (q_status),
      .head_data            (q_head_data),
      .q_pop                (q_pop),
      .rsp_empty            (empty),
      .rsp_pop              (pop),
      .rsp_coordinate_index (rsp_coordinate_index),
      .rsp_numerator        (rsp_numerator),
      .rsp_fraction         (rsp_fraction),
      .rsp_last_of_point    (rsp_last_of_point),
      .rsp_final_point      (rsp_final_point)
   );

endmodule

/* hw/rtl/slpg_queue.sv */
// Small register queue holding whole points between the front and the back.
module slpg_queue #(
   parameter int WIDTH = 65
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [WIDTH-1:0]        push_data,
   input  logic                    pop,
   output logic [WIDTH-1:0]        head_data,
   output slpg_pkg::q_status_type  status
);

   localparam int PTR_W = (slpg_pkg::QUEUE_DEPTH > 1) ? $clog2(slpg_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(slpg_pkg::QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [slpg_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(slpg_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(slpg_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data    = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(slpg_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

/* hw/rtl/slpg_front.sv */
// Front end: accepts requests, holds the lattice walk and queues whole points.
module slpg_front #(
   parameter int MAX_DIMENSIONS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  slpg_pkg::cfg_type                   cfg,
   input  logic                                clear,
   input  logic                                push,
   input  logic                                restart,
   input  slpg_pkg::q_status_type              q_status,
   output logic                                q_push,
   output logic [MAX_DIMENSIONS*slpg_pkg::NUM_W:0] q_data
);

   localparam int NW     = slpg_pkg::NUM_W;
   localparam int DW     = slpg_pkg::D_W;
   localparam int FREE_N = MAX_DIMENSIONS - 1;
   localparam int FIDX_W = (FREE_N > 1) ? $clog2(FREE_N) : 1;

   logic [NW-1:0]     free_ff [FREE_N];
   logic [NW-1:0]     free_in [FREE_N];
   logic [NW-1:0]     sum_ff, sum_in;
   logic [NW-1:0]     cur [FREE_N];
   logic [NW-1:0]     cur_sum;
   logic [NW-1:0]     jval;
   logic [FIDX_W-1:0] jidx;
   logic              found;
   logic [DW-1:0]     nfree;
   logic              fin;
   logic              accept;

   assign accept = push && !q_status.full;
   assign nfree  = cfg.d - 1'b1;

   always_comb begin
      // restart drops the walk back to the first point
      for (int k = 0; k < FREE_N; k++) begin
         cur[k] = restart ? '0 : free_ff[k];
      end
      cur_sum = restart ? '0 : sum_ff;
      if (cur_sum > cfg.h) begin
         for (int k = 0; k < FREE_N; k++) begin
            cur[k] = '0;
         end
         cur_sum = '0;
      end
      fin = (cur[0] == cfg.h);

      // point payload: free numerators, then the dependent one, then zeros
      for (int k = 0; k < MAX_DIMENSIONS; k++) begin
         if (DW'(k) < nfree) begin
            q_data[k*NW +: NW] = cur[k];
         end else if (DW'(k) == nfree) begin
            q_data[k*NW +: NW] = cfg.h - cur_sum;
         end else begin
            q_data[k*NW +: NW] = '0;
         end
      end
      q_data[MAX_DIMENSIONS*NW] = fin;

      // rightmost nonzero free numerator
      found = 1'b0;
      jidx  = '0;
      jval  = '0;
      for (int k = 0; k < FREE_N; k++) begin
         if (DW'(k) < nfree && cur[k] != '0) begin
            found = 1'b1;
            jidx  = FIDX_W'(k);
            jval  = cur[k];
         end
      end

      // advance to the next point
      for (int k = 0; k < FREE_N; k++) begin
         free_in[k] = cur[k];
      end
      sum_in = cur_sum;
      if (cur_sum < cfg.h) begin
         for (int k = 0; k < FREE_N; k++) begin
            if (DW'(k) == nfree - 1'b1) begin
               free_in[k] = cur[k] + 1'b1;
            end
         end
         sum_in = cur_sum + 1'b1;
      end else if (!found || jidx == '0) begin
         for (int k = 0; k < FREE_N; k++) begin
            free_in[k] = '0;
         end
         sum_in = '0;
      end else begin
         for (int k = 0; k < FREE_N; k++) begin
            if (FIDX_W'(k) == jidx) begin
               free_in[k] = '0;
            end else if (FIDX_W'(k) == jidx - 1'b1) begin
               free_in[k] = cur[k] + 1'b1;
            end
         end
         sum_in = cur_sum - jval + 1'b1;
      end
   end

   assign q_push = accept;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         for (int k = 0; k < FREE_N; k++) begin
            free_ff[k] <= '0;
         end
         sum_ff <= '0;
      end else if (accept) begin
         free_ff <= free_in;
         sum_ff  <= sum_in;
      end
   end

   // the running sum of free numerators never exceeds H
   assert property (@(posedge clock) disable iff (reset) sum_ff <= cfg.h)
      else $error("front: running numerator sum above partitions");

endmodule

/* hw/rtl/slpg_back.sv */
// Back end: divides each coordinate by H and presents results one at a time.
module slpg_back #(
   parameter int MAX_DIMENSIONS = 8,
   parameter int FRACTION_BITS  = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  slpg_pkg::cfg_type                       cfg,
   input  slpg_pkg::q_status_type                  q_status,
   input  logic [MAX_DIMENSIONS*slpg_pkg::NUM_W:0] head_data,
   output logic                                    q_pop,
   output logic                                    rsp_empty,
   input  logic                                    rsp_pop,
   output logic [$clog2(MAX_DIMENSIONS)-1:0]       rsp_coordinate_index,
   output logic [slpg_pkg::NUM_W-1:0]              rsp_numerator,
   output logic [FRACTION_BITS:0]                  rsp_fraction,
   output logic                                    rsp_last_of_point,
   output logic                                    rsp_final_point
);

   localparam int NW      = slpg_pkg::NUM_W;
   localparam int DW      = slpg_pkg::D_W;
   localparam int IDX_W   = $clog2(MAX_DIMENSIONS);
   localparam int DIV_CYC = (FRACTION_BITS + slpg_pkg::DIV_BITS - 1) / slpg_pkg::DIV_BITS;
   localparam int NB      = DIV_CYC * slpg_pkg::DIV_BITS;
   localparam int Q_W     = NB + 1;
   localparam int STEP_W  = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

   slpg_pkg::back_state_type state_ff, state_in;
   logic [IDX_W-1:0]  coord_ff, coord_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [NW-1:0]     rem_ff, rem_in;
   logic [Q_W-1:0]    quo_ff, quo_in;

   logic                   out_valid_ff;
   logic [IDX_W-1:0]       out_idx_ff;
   logic [NW-1:0]          out_num_ff;
   logic [FRACTION_BITS:0] out_frac_ff;
   logic                   out_last_ff;
   logic                   out_fin_ff;

   logic [NW-1:0]  cur_num, nxt_num, first_num;
   logic [NW-1:0]  step_rem;
   logic [Q_W-1:0] step_quo;
   logic [NW:0]    r2;
   logic           last_step, last_coord, slot_free, out_load;

   always_comb begin
      cur_num = '0;
      nxt_num = '0;
      for (int k = 0; k < MAX_DIMENSIONS; k++) begin
         if (IDX_W'(k) == coord_ff) begin
            cur_num = head_data[k*NW +: NW];
         end
         if (IDX_W'(k) == coord_ff + 1'b1) begin
            nxt_num = head_data[k*NW +: NW];
         end
      end
      first_num = head_data[NW-1:0];
   end

   // restoring division, DIV_BITS quotient bits per cycle
   always_comb begin
      step_rem = rem_ff;
      step_quo = quo_ff;
      r2       = '0;
      for (int b = 0; b < slpg_pkg::DIV_BITS; b++) begin
         r2 = {step_rem, 1'b0};
         if (r2 >= {1'b0, cfg.h}) begin
            step_rem = NW'(r2 - {1'b0, cfg.h});
            step_quo = {step_quo[Q_W-2:0], 1'b1};
         end else begin
            step_rem = r2[NW-1:0];
            step_quo = {step_quo[Q_W-2:0], 1'b0};
         end
      end
   end

   assign last_step  = (step_ff == STEP_W'(DIV_CYC - 1));
   assign last_coord = (DW'(coord_ff) == cfg.d - 1'b1);
   assign slot_free  = !out_valid_ff || rsp_pop;

   always_comb begin
      state_in = state_ff;
      coord_in = coord_ff;
      step_in  = step_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      q_pop    = 1'b0;
      out_load = 1'b0;
      case (state_ff)
         slpg_pkg::BACK_IDLE: begin
            if (!q_status.empty) begin
               coord_in = '0;
               step_in  = '0;
               // numerator equal to H gives exactly one
               rem_in   = (first_num == cfg.h) ? '0 : first_num;
               quo_in   = (first_num == cfg.h) ? Q_W'(1) : '0;
               state_in = slpg_pkg::BACK_DIVIDE;
            end
         end
         slpg_pkg::BACK_DIVIDE: begin
            if (!last_step) begin
               rem_in  = step_rem;
               quo_in  = step_quo;
               step_in = step_ff + 1'b1;
            end else if (slot_free) begin
               out_load = 1'b1;
               if (last_coord) begin
                  q_pop    = 1'b1;
                  state_in = slpg_pkg::BACK_IDLE;
               end else begin
                  coord_in = coord_ff + 1'b1;
                  step_in  = '0;
                  rem_in   = (nxt_num == cfg.h) ? '0 : nxt_num;
                  quo_in   = (nxt_num == cfg.h) ? Q_W'(1) : '0;
               end
            end
         end
         default: begin
            state_in = slpg_pkg::BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= slpg_pkg::BACK_IDLE;
         coord_ff <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         coord_ff <= coord_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_idx_ff  <= coord_ff;
         out_num_ff  <= cur_num;
         out_frac_ff <= step_quo[NB -: FRACTION_BITS + 1];
         out_last_ff <= last_coord;
         out_fin_ff  <= head_data[MAX_DIMENSIONS*NW];
      end
   end

   assign rsp_empty            = !out_valid_ff;
   assign rsp_coordinate_index = out_idx_ff;
   assign rsp_numerator        = out_num_ff;
   assign rsp_fraction         = out_frac_ff;
   assign rsp_last_of_point    = out_last_ff;
   assign rsp_final_point      = out_fin_ff;

   assert property (@(posedge clock) disable iff (reset)
      state_ff == slpg_pkg::BACK_DIVIDE |-> !q_status.empty)
      else $error("back: dividing with no point at the queue head");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == slpg_pkg::BACK_DIVIDE |-> rem_ff < cfg.h)
      else $error("back: divider remainder not below partitions");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == slpg_pkg::BACK_DIVIDE |-> DW'(coord_ff) < cfg.d)
      else $error("back: coordinate index beyond point dimension");

endmodule
